// File: src/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit heap allocator: request and
// response words, status codes, register indexes and store write controls.
// ----------------------------------------------------------------------------
package ffa_pkg;

    // Default geometry
    localparam int HEAP_BLOCKS_DEF = 4096;
    localparam int BLOCK_BYTES_DEF = 64;

    // Size header in front of every allocated region
    localparam int HDR_BYTES = 4;

    // Field widths
    localparam int ADDR_W    = 48;
    localparam int REQ_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 48;
    localparam int HB_CFG_W  = 13;

    // Request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_START  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BLOCKS = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVL_NEXT  = 3'd1,
        ST_OVL_PREV  = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_PAST_END  = 3'd4,
        ST_NO_FIT    = 3'd5
    } status_t;

    typedef struct packed {
        logic              cmd;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] pointer;
    } in_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        status_t           status;
    } out_word_t;

    // Write enables of the run store
    typedef struct packed {
        logic size_we;
        logic next_we;
    } store_we_t;

endpackage

// File: src/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an address-ordered free list of fixed-size blocks,
// with coalescing on free.
// ----------------------------------------------------------------------------
// After reset and after every heap_blocks write the block sweeps every entry of
// its run store and takes no request meanwhile. Each request then walks the
// free list one run per cycle through the single read port of the run store.
// An allocation that splits a run adds a step that writes the size header of
// the tail it hands out, and one refused at once (oversized or empty list) goes
// straight to its response. A free whose region becomes the new head skips the
// walk to its neighbor; one that links in between two runs adds a link step and
// one that merges with the next run adds a merge write; a refused free ends
// after its check. One request is in work at a time; the response register
// lets the next request enter while a response waits, and a request that
// finishes while that register is still full holds until it drains.
// BLOCK_BYTES must be a power of two.
module first_fit_heap_allocator #(
    parameter int HEAP_BLOCKS = ffa_pkg::HEAP_BLOCKS_DEF,
    parameter int BLOCK_BYTES = ffa_pkg::BLOCK_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ffa_pkg::in_word_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ffa_pkg::out_word_t                 out_data,
    input  logic                               cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffa_pkg::CFG_W-1:0]          cfg_data
);
    import ffa_pkg::*;

    localparam int IW  = $clog2(HEAP_BLOCKS + 1);
    localparam int AW  = $clog2(HEAP_BLOCKS);
    localparam int BSH = $clog2(BLOCK_BYTES);
    localparam int HB_RESET = (HEAP_BLOCKS < 4096) ? HEAP_BLOCKS : 4096;
    localparam logic [IW-1:0] END_MARK = IW'(HEAP_BLOCKS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_WALK,
        S_A_WR2,
        S_F_CHK,
        S_F_CHK2,
        S_F_SIZE,
        S_F_WALK,
        S_F_LINK2,
        S_F_COAL,
        S_F_COALW,
        S_RESP
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_reg;
    logic [IW-1:0]     head_reg;
    logic              head_vld_reg;
    logic [ADDR_W-1:0] hs_reg;
    logic [IW-1:0]     hb_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] off_reg;
    logic [IW-1:0]     need_reg;
    logic [IW-1:0]     cur_reg;
    logic [IW-1:0]     prev_reg;
    logic [IW-1:0]     blk_reg;
    logic [IW-1:0]     sz_reg;
    logic [IW-1:0]     nx_reg;
    logic              hasn_reg;
    logic [IW-1:0]     at_reg;
    logic [IW-1:0]     ret_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    status_t           res_status_reg;
    logic              out_valid_reg;
    out_word_t         out_data_reg;

    // Store interface
    logic [AW-1:0]     rd_addr;
    store_we_t         st_we;
    logic [AW-1:0]     size_waddr;
    logic [IW-1:0]     size_wdata;
    logic [AW-1:0]     next_waddr;
    logic [IW-1:0]     next_wdata;
    logic [IW-1:0]     size_rd;
    logic [IW-1:0]     next_rd;

    // Request arithmetic
    logic [REQ_W:0]     need_sum;
    logic [REQ_W:0]     need_full;
    logic               need_big;
    logic [ADDR_W:0]    ptr_floor;
    logic [ADDR_W-1:0]  off_blk;
    logic               off_misaligned;
    logic [IW:0]        blk_end_rd;
    logic [IW:0]        blk_end;
    logic [IW:0]        cur_end;
    logic [IW:0]        at_end;
    logic [IW:0]        hb_ext;
    logic               walk_ovl_next;
    logic               hb_write;
    logic [HB_CFG_W-1:0] hb_cfg;
    logic [IW-1:0]      hb_clamped;

    assign need_sum  = {1'b0, in_data.request_bytes}
                     + (REQ_W+1)'(HDR_BYTES + BLOCK_BYTES - 1);
    assign need_full = need_sum >> BSH;
    assign need_big  = need_full > (REQ_W+1)'(HEAP_BLOCKS);

    assign ptr_floor      = {1'b0, hs_reg} + (ADDR_W+1)'(HDR_BYTES);
    assign off_blk        = off_reg >> BSH;
    assign off_misaligned = (off_reg & ADDR_W'(BLOCK_BYTES - 1)) != '0;

    assign blk_end_rd = {1'b0, blk_reg} + {1'b0, size_rd};
    assign blk_end    = {1'b0, blk_reg} + {1'b0, sz_reg};
    assign cur_end    = {1'b0, cur_reg} + {1'b0, size_rd};
    assign at_end     = {1'b0, at_reg} + {1'b0, sz_reg};
    assign hb_ext     = {1'b0, hb_reg};

    // The run after the stop point starts inside the freed region
    assign walk_ovl_next = (next_rd != END_MARK) && ({1'b0, next_rd} < blk_end);

    assign hb_write = cfg_we && (cfg_index == REG_HEAP_BLOCKS);

    // Clamp a heap_blocks write to 1..HEAP_BLOCKS
    assign hb_cfg = cfg_data[HB_CFG_W-1:0];
    always_comb
    begin
        if (32'(hb_cfg) > 32'(HEAP_BLOCKS))
        begin
            hb_clamped = IW'(HEAP_BLOCKS);
        end
        else if (hb_cfg == '0)
        begin
            hb_clamped = IW'(1);
        end
        else
        begin
            hb_clamped = IW'(hb_cfg);
        end
    end

    // Drive store reads and writes from the sequencer state
    always_comb
    begin
        rd_addr    = head_reg[AW-1:0];
        st_we      = '0;
        size_waddr = cur_reg[AW-1:0];
        size_wdata = '0;
        next_waddr = cur_reg[AW-1:0];
        next_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                st_we.size_we = 1'b1;
                st_we.next_we = 1'b1;
                size_waddr    = clr_reg;
                next_waddr    = clr_reg;
                size_wdata    = (clr_reg == '0) ? hb_reg : '0;
                next_wdata    = (clr_reg == '0) ? END_MARK : '0;
            end
            S_A_WALK:
            begin
                if (size_rd >= need_reg)
                begin
                    if (size_rd == need_reg)
                    begin
                        // exact fit: unlink behind the previous run
                        st_we.next_we = (cur_reg != head_reg);
                        next_waddr    = prev_reg[AW-1:0];
                        next_wdata    = next_rd;
                    end
                    else
                    begin
                        // split: shrink the run, hand out its tail
                        st_we.size_we = 1'b1;
                        size_waddr    = cur_reg[AW-1:0];
                        size_wdata    = size_rd - need_reg;
                    end
                end
                else if (next_rd != END_MARK)
                begin
                    rd_addr = next_rd[AW-1:0];
                end
            end
            S_A_WR2:
            begin
                st_we.size_we = 1'b1;
                size_waddr    = ret_reg[AW-1:0];
                size_wdata    = need_reg;
            end
            S_F_CHK2:
            begin
                rd_addr = off_blk[AW-1:0];
            end
            S_F_SIZE:
            begin
                if (!head_vld_reg || head_reg > blk_reg)
                begin
                    // no run in front: the freed region becomes the head
                    st_we.next_we = 1'b1;
                    next_waddr    = blk_reg[AW-1:0];
                    next_wdata    = head_vld_reg ? head_reg : END_MARK;
                end
            end
            S_F_WALK:
            begin
                if (next_rd == END_MARK || next_rd >= blk_reg)
                begin
                    // write only when the region fits between its neighbors
                    if (!walk_ovl_next && cur_end == {1'b0, blk_reg})
                    begin
                        st_we.size_we = 1'b1;
                        size_waddr    = cur_reg[AW-1:0];
                        size_wdata    = sz_reg + size_rd;
                    end
                    else if (!walk_ovl_next && cur_end < {1'b0, blk_reg})
                    begin
                        st_we.next_we = 1'b1;
                        next_waddr    = cur_reg[AW-1:0];
                        next_wdata    = blk_reg;
                    end
                end
                else
                begin
                    rd_addr = next_rd[AW-1:0];
                end
            end
            S_F_LINK2:
            begin
                st_we.next_we = 1'b1;
                next_waddr    = blk_reg[AW-1:0];
                next_wdata    = nx_reg;
            end
            S_F_COAL:
            begin
                rd_addr = nx_reg[AW-1:0];
            end
            S_F_COALW:
            begin
                st_we.size_we = 1'b1;
                st_we.next_we = 1'b1;
                size_waddr    = at_reg[AW-1:0];
                next_waddr    = at_reg[AW-1:0];
                size_wdata    = sz_reg + size_rd;
                next_wdata    = next_rd;
            end
            default:
            begin
            end
        endcase
    end

    ffa_run_store #(
        .HEAP_BLOCKS (HEAP_BLOCKS)
    ) u_store (
        .clk        (clk),
        .rd_addr    (rd_addr),
        .we         (st_we),
        .size_waddr (size_waddr),
        .size_wdata (size_wdata),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .size_rd    (size_rd),
        .next_rd    (next_rd)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer, list head, registers and response word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            head_reg       <= '0;
            head_vld_reg   <= 1'b1;
            hs_reg         <= '0;
            hb_reg         <= IW'(HB_RESET);
            out_valid_reg  <= 1'b0;
            res_status_reg <= ST_OK;
        end
        else
        begin
            // Drop the response word once taken, unless a new one loads now
            if (out_valid_reg && out_ready && !(state_reg == S_RESP && !hb_write))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we && cfg_index == REG_HEAP_START)
            begin
                hs_reg <= cfg_data[ADDR_W-1:0];
            end

            // A heap size write rebuilds the list
            if (hb_write)
            begin
                hb_reg       <= hb_clamped;
                head_reg     <= '0;
                head_vld_reg <= 1'b1;
                clr_reg      <= '0;
                state_reg    <= S_CLEAR;
            end
            else
            begin
                case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_reg + AW'(1);
                        if (clr_reg == AW'(HEAP_BLOCKS - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (in_valid)
                        begin
                            res_addr_reg <= '0;
                            ptr_reg      <= in_data.pointer;
                            cur_reg      <= head_reg;
                            prev_reg     <= head_reg;
                            need_reg     <= IW'(need_full);
                            if (in_data.cmd == CMD_FREE)
                            begin
                                state_reg <= S_F_CHK;
                            end
                            else if (need_big || !head_vld_reg)
                            begin
                                res_status_reg <= ST_NO_FIT;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                state_reg <= S_A_WALK;
                            end
                        end
                    end
                    S_A_WALK:
                    begin
                        if (size_rd >= need_reg)
                        begin
                            if (size_rd == need_reg)
                            begin
                                if (cur_reg == head_reg)
                                begin
                                    head_reg     <= next_rd;
                                    head_vld_reg <= (next_rd != END_MARK);
                                end
                                res_addr_reg   <= hs_reg + (ADDR_W'(cur_reg) << BSH)
                                                + ADDR_W'(HDR_BYTES);
                                res_status_reg <= ST_OK;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                ret_reg   <= cur_reg + size_rd - need_reg;
                                state_reg <= S_A_WR2;
                            end
                        end
                        else if (next_rd == END_MARK)
                        begin
                            res_status_reg <= ST_NO_FIT;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            prev_reg <= cur_reg;
                            cur_reg  <= next_rd;
                        end
                    end
                    S_A_WR2:
                    begin
                        res_addr_reg   <= hs_reg + (ADDR_W'(ret_reg) << BSH)
                                        + ADDR_W'(HDR_BYTES);
                        res_status_reg <= ST_OK;
                        state_reg      <= S_RESP;
                    end
                    S_F_CHK:
                    begin
                        off_reg <= ptr_reg - hs_reg - ADDR_W'(HDR_BYTES);
                        if ({1'b0, ptr_reg} < ptr_floor)
                        begin
                            res_status_reg <= ST_OUTSIDE;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_F_CHK2;
                        end
                    end
                    S_F_CHK2:
                    begin
                        blk_reg <= IW'(off_blk);
                        if (off_misaligned || off_blk >= ADDR_W'(hb_reg))
                        begin
                            res_status_reg <= ST_OUTSIDE;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_F_SIZE;
                        end
                    end
                    S_F_SIZE:
                    begin
                        sz_reg <= size_rd;
                        cur_reg <= head_reg;
                        if (size_rd == '0)
                        begin
                            res_status_reg <= ST_OUTSIDE;
                            state_reg      <= S_RESP;
                        end
                        else if (blk_end_rd > hb_ext)
                        begin
                            res_status_reg <= ST_PAST_END;
                            state_reg      <= S_RESP;
                        end
                        else if (!head_vld_reg || head_reg > blk_reg)
                        begin
                            if (head_vld_reg && {1'b0, head_reg} < blk_end_rd)
                            begin
                                res_status_reg <= ST_OVL_NEXT;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                head_reg     <= blk_reg;
                                head_vld_reg <= 1'b1;
                                at_reg       <= blk_reg;
                                nx_reg       <= head_reg;
                                hasn_reg     <= head_vld_reg;
                                state_reg    <= S_F_COAL;
                            end
                        end
                        else
                        begin
                            state_reg <= S_F_WALK;
                        end
                    end
                    S_F_WALK:
                    begin
                        if (next_rd == END_MARK || next_rd >= blk_reg)
                        begin
                            nx_reg   <= next_rd;
                            hasn_reg <= (next_rd != END_MARK);
                            if (walk_ovl_next)
                            begin
                                res_status_reg <= ST_OVL_NEXT;
                                state_reg      <= S_RESP;
                            end
                            else if (cur_end > {1'b0, blk_reg})
                            begin
                                res_status_reg <= ST_OVL_PREV;
                                state_reg      <= S_RESP;
                            end
                            else if (cur_end == {1'b0, blk_reg})
                            begin
                                at_reg    <= cur_reg;
                                sz_reg    <= sz_reg + size_rd;
                                state_reg <= S_F_COAL;
                            end
                            else
                            begin
                                at_reg    <= blk_reg;
                                state_reg <= S_F_LINK2;
                            end
                        end
                        else
                        begin
                            cur_reg <= next_rd;
                        end
                    end
                    S_F_LINK2:
                    begin
                        state_reg <= S_F_COAL;
                    end
                    S_F_COAL:
                    begin
                        if (hasn_reg && at_end == {1'b0, nx_reg})
                        begin
                            state_reg <= S_F_COALW;
                        end
                        else
                        begin
                            res_status_reg <= ST_OK;
                            state_reg      <= S_RESP;
                        end
                    end
                    S_F_COALW:
                    begin
                        res_status_reg <= ST_OK;
                        state_reg      <= S_RESP;
                    end
                    S_RESP:
                    begin
                        if (!out_valid_reg || out_ready)
                        begin
                            out_data_reg.address <= res_addr_reg;
                            out_data_reg.status  <= res_status_reg;
                            out_valid_reg        <= 1'b1;
                            state_reg            <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // An accepted request holds off the next one
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in work");

    // A walk never points past the store
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_WALK || state_reg == S_F_WALK) |-> cur_reg < END_MARK)
        else $error("list walk left the heap");

    // Only a successful allocation hands out an address
    a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.address != '0) |-> out_data.status == ST_OK)
        else $error("address returned with an error status");

endmodule

// File: src/ffa_run_store.sv
// ----------------------------------------------------------------------------
// ffa_run_store
// Run size and next-link memories, one entry per heap block. One shared read
// address with registered data, one write port per memory.
// ----------------------------------------------------------------------------
module ffa_run_store #(
    parameter int HEAP_BLOCKS = ffa_pkg::HEAP_BLOCKS_DEF
) (
    input  logic                                 clk,
    input  logic [$clog2(HEAP_BLOCKS)-1:0]       rd_addr,
    input  ffa_pkg::store_we_t                   we,
    input  logic [$clog2(HEAP_BLOCKS)-1:0]       size_waddr,
    input  logic [$clog2(HEAP_BLOCKS+1)-1:0]     size_wdata,
    input  logic [$clog2(HEAP_BLOCKS)-1:0]       next_waddr,
    input  logic [$clog2(HEAP_BLOCKS+1)-1:0]     next_wdata,
    output logic [$clog2(HEAP_BLOCKS+1)-1:0]     size_rd,
    output logic [$clog2(HEAP_BLOCKS+1)-1:0]     next_rd
);
    import ffa_pkg::*;

    localparam int IW = $clog2(HEAP_BLOCKS + 1);

    logic [IW-1:0] size_mem [HEAP_BLOCKS];
    logic [IW-1:0] next_mem [HEAP_BLOCKS];

    // Size memory
    always_ff @(posedge clk)
    begin
        if (we.size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_rd <= size_mem[rd_addr];
    end

    // Link memory
    always_ff @(posedge clk)
    begin
        if (we.next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rd <= next_mem[rd_addr];
    end

endmodule

// File: tb/sv/tb_first_fit_heap_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Drives allocate and free words into the first-fit allocator under random
// handshake gaps and checks every response word against a heap model that
// tracks the free list, the size headers and the heap registers.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
    import ffa_pkg::*;

    localparam int NRUN        = HEAP_BLOCKS_DEF;
    localparam int BLK         = BLOCK_BYTES_DEF;
    localparam int STALL_LIMIT = 40000;

    // Heap model with the queue of expected response words
    class alloc_scoreboard;
        longint unsigned base;
        int unsigned     blocks;
        int unsigned     head;
        bit              head_ok;
        int unsigned     sz [NRUN];
        int unsigned     nxt[NRUN];
        out_word_t       expected[$];
        longint unsigned live[$];
        longint unsigned last_addr;
        int errors, n_alloc_ok, n_free_ok, n_fail, n_checked;

        function void clear_list();
            foreach (sz[i])
            begin
                sz[i]  = 0;
                nxt[i] = 0;
            end
            head    = 0;
            head_ok = 1;
            sz[0]   = blocks;
            nxt[0]  = NRUN;
            live.delete();
        endfunction

        function new();
            base   = 0;
            blocks = NRUN;
            clear_list();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            longint unsigned v;
            if (idx == REG_HEAP_START)
            begin
                base = 64'(data);
            end
            else
            begin
                v = 64'(data) & 64'h1FFF;
                if (v < 1) v = 1;
                if (v > NRUN) v = NRUN;
                blocks = 32'(v);
                clear_list();
            end
        endfunction

        function int unsigned size_at(int unsigned b);
            return (b < NRUN) ? sz[b] : 0;
        endfunction

        function int unsigned next_at(int unsigned b);
            return (b < NRUN) ? nxt[b] : NRUN;
        endfunction

        function void set_size(int unsigned b, int unsigned v);
            if (b < NRUN) sz[b] = v;
        endfunction

        function void set_next(int unsigned b, int unsigned v);
            if (b < NRUN) nxt[b] = v;
        endfunction

        // last free run at or before blk
        function int unsigned prev_run(int unsigned blk, output bit found);
            int unsigned cur, nx;
            found = 0;
            if (!head_ok || head > blk) return 0;
            found = 1;
            cur   = head;
            for (int i = 0; i < NRUN; i++)
            begin
                nx = next_at(cur);
                if (nx == NRUN || nx >= blk) break;
                cur = nx;
            end
            return cur;
        endfunction

        function void allocate(longint unsigned req, output longint unsigned addr,
                               output status_t st);
            longint unsigned need;
            int unsigned cur, s, nx, p, ret, i;
            bit ok, hasp;
            addr = 0;
            st   = ST_NO_FIT;
            need = (req + HDR_BYTES + BLK - 1) / BLK;
            if (need > NRUN || !head_ok) return;
            cur = head;
            ok  = 0;
            for (i = 0; i < NRUN; i++)
            begin
                if (size_at(cur) >= need)
                begin
                    ok = 1;
                    break;
                end
                nx = next_at(cur);
                if (nx == NRUN) break;
                cur = nx;
            end
            if (!ok) return;
            s = size_at(cur);
            if (s == need)
            begin
                p  = prev_run(cur, hasp);
                nx = next_at(cur);
                if (!hasp || p == cur)
                begin
                    head    = nx;
                    head_ok = (nx != NRUN);
                end
                else
                begin
                    set_next(p, nx);
                end
                ret = cur;
            end
            else
            begin
                ret = cur + s - 32'(need);
                set_size(cur, s - 32'(need));
            end
            set_size(ret, 32'(need));
            addr = (base + longint'(ret) * BLK + HDR_BYTES) & 64'hFFFF_FFFF_FFFF;
            st   = ST_OK;
        endfunction

        function status_t release_region(longint unsigned ptr);
            longint unsigned off;
            int unsigned blk, bsz, p, ps, nx, at;
            bit hasp, hasn;
            if (ptr < base + HDR_BYTES) return ST_OUTSIDE;
            off = ptr - HDR_BYTES - base;
            if (off % BLK != 0) return ST_OUTSIDE;
            off = off / BLK;
            if (off >= blocks) return ST_OUTSIDE;
            blk = 32'(off);
            bsz = size_at(blk);
            if (bsz == 0) return ST_OUTSIDE;
            if (longint'(blk) + bsz > blocks) return ST_PAST_END;
            p = prev_run(blk, hasp);
            if (!hasp)
            begin
                hasn = head_ok;
                nx   = head;
                if (hasn && nx < blk + bsz) return ST_OVL_NEXT;
                set_size(blk, bsz);
                set_next(blk, hasn ? nx : NRUN);
                head    = blk;
                head_ok = 1;
                at      = blk;
            end
            else
            begin
                ps   = size_at(p);
                nx   = next_at(p);
                hasn = (nx != NRUN);
                if (hasn && nx < blk + bsz) return ST_OVL_NEXT;
                if (p + ps > blk) return ST_OVL_PREV;
                if (p + ps == blk)
                begin
                    bsz = bsz + ps;
                    set_size(p, bsz);
                    at = p;
                end
                else
                begin
                    set_next(p, blk);
                    set_size(blk, bsz);
                    set_next(blk, nx);
                    at = blk;
                end
            end
            if (!hasn)
            begin
                set_next(at, NRUN);
            end
            else if (at + bsz == nx)
            begin
                set_size(at, bsz + size_at(nx));
                set_next(at, next_at(nx));
            end
            return ST_OK;
        endfunction

        // note an accepted request word and queue its response
        function void note_request(in_word_t w);
            out_word_t exp_w;
            longint unsigned a;
            status_t st;
            a = 0;
            if (w.cmd == CMD_ALLOC)
            begin
                allocate(64'(w.request_bytes), a, st);
                if (st == ST_OK)
                begin
                    live.push_back(a);
                    n_alloc_ok++;
                end
                last_addr = a;
            end
            else
            begin
                st = release_region(64'(w.pointer));
                if (st == ST_OK) n_free_ok++;
            end
            if (st != ST_OK) n_fail++;
            exp_w.address = ADDR_W'(a);
            exp_w.status  = st;
            expected.push_back(exp_w);
        endfunction

        // compare a response word with the oldest expectation
        function void check_result(out_word_t got);
            out_word_t exp_w;
            n_checked++;
            if (expected.size() == 0)
            begin
                $error("unexpected response word: address %h status %0d",
                       got.address, got.status);
                errors++;
                return;
            end
            exp_w = expected.pop_front();
            if (got.address !== exp_w.address)
            begin
                $error("address: expected %h actual %h", exp_w.address, got.address);
                errors++;
            end
            if (got.status !== exp_w.status)
            begin
                $error("status: expected %0d actual %0d", exp_w.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_word_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    alloc_scoreboard sb;
    bit quiet;
    bit hold_req;
    int stall_cycles;

    first_fit_heap_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Check response words and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d words outstanding", sb.expected.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (300) @(negedge clk);
                hold_req = 0;
            end
            out_ready = quiet ? 1'b1 : ($urandom_range(99) >= 12);
        end
    end

    // Offer one request word and hold it until accepted
    task automatic push_request(input in_word_t w);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 12)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = w;
        do @(posedge clk); while (!in_ready);
        sb.note_request(w);
    endtask

    task automatic alloc_req(input logic [REQ_W-1:0] bytes);
        in_word_t w;
        w.cmd           = CMD_ALLOC;
        w.request_bytes = bytes;
        w.pointer       = ADDR_W'({$urandom, $urandom});
        push_request(w);
    endtask

    task automatic free_req(input longint unsigned ptr);
        in_word_t w;
        w.cmd           = CMD_FREE;
        w.request_bytes = $urandom;
        w.pointer       = ADDR_W'(ptr);
        push_request(w);
    endtask

    // Drain responses, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    // One random request word, mostly frees of live regions and small allocations
    task automatic random_request();
        int r;
        int k;
        longint unsigned p;
        r = $urandom_range(99);
        if (r < 45)
        begin
            alloc_req($urandom_range(0, 8 * BLK));
        end
        else if (r < 50)
        begin
            alloc_req($urandom);
        end
        else if (r < 82 && sb.live.size() != 0)
        begin
            k = $urandom_range(sb.live.size() - 1);
            p = sb.live[k];
            sb.live.delete(k);
            free_req(p);
        end
        else if (r < 87)
        begin
            free_req({$urandom, $urandom});
        end
        else if (r < 93)
        begin
            p = sb.base + longint'($urandom_range(sb.blocks - 1)) * BLK + HDR_BYTES;
            if ($urandom_range(3) == 0) p = p + $urandom_range(1, BLK - 1);
            free_req(p);
        end
        else
        begin
            alloc_req($urandom_range(0, sb.blocks * BLK));
        end
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            quiet = (i >= count / 2 && i < count / 2 + 60);
            random_request();
        end
        quiet = 0;
    endtask

    initial
    begin
        longint unsigned p1, p2, p3, whole;
        sb        = new();
        quiet     = 0;
        hold_req  = 0;
        stall_cycles = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_HEAP_START;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: sizes, bad pointers, double free, coalescing, empty list
        alloc_req(0);
        p1 = sb.last_addr;
        alloc_req(60);
        p2 = sb.last_addr;
        alloc_req(61);
        p3 = sb.last_addr;
        alloc_req(32'hFFFF_FFFF);
        free_req(p2);
        free_req(p2);
        free_req(64'd3);
        free_req(p1 + 1);
        free_req(64'hFFFF_FFFF_FFFF);
        free_req(64'(10 * BLK + HDR_BYTES));
        free_req(p1);
        free_req(p3);
        sb.live.delete();
        alloc_req(NRUN * BLK - HDR_BYTES);
        whole = sb.last_addr;
        alloc_req(0);
        free_req(whole);
        alloc_req(NRUN * BLK - HDR_BYTES + 1);

        random_phase(300);

        // Tiny heap at the top of the address space, with a receiver hold-off
        write_reg(REG_HEAP_START, 48'hFFFF_FFFF_FFC0);
        write_reg(REG_HEAP_BLOCKS, 48'h0);
        alloc_req(0);
        free_req(64'h0000_0000_0004);
        write_reg(REG_HEAP_START, 48'hFFFF_FFFF_F000);
        write_reg(REG_HEAP_BLOCKS, {35'h7_FFFF_FFFF, 13'd48});
        hold_req = 1;
        random_phase(250);

        write_reg(REG_HEAP_BLOCKS, 48'h1FFF);
        write_reg(REG_HEAP_START, ADDR_W'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFC0);
        random_phase(300);

        write_reg(REG_HEAP_BLOCKS, 48'd1);
        random_phase(50);
        write_reg(REG_HEAP_START, 48'h0);
        write_reg(REG_HEAP_BLOCKS, 48'd200);
        random_phase(200);

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected.size() != 0) @(negedge clk);
        repeat (100) @(posedge clk);

        $display("checked %0d response words: %0d allocations and %0d frees succeeded,",
                 sb.n_checked, sb.n_alloc_ok, sb.n_free_ok);
        $display("%0d requests refused, over six heap settings", sb.n_fail);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
